// ----- hdl/sle_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sle_pkg: shared codes for the sorted list engine
// Opcodes and result status codes.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;  // unused, treated as search

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // one-hot sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

endpackage : sle_pkg
`default_nettype wire

// ----- hdl/sorted_list_engine.sv -----
`default_nettype none
// Sequence: every request first scans the stored entries, one entry per cycle, for the
//   insert position and the first equal entry; an accepted insert then shifts the entries
//   from its position up, a found delete shifts those above the hit down, before the result.
// Flow: one request in flight; the next is taken in the cycle after the result
//   is registered, and a result waiting in the output register does not block it.
// Reset: synchronous, active low; clears occupancy, control and output valid.
// ----------------------------------------------------------------------------
// sorted_list_engine: ordered store of signed 32-bit keys
// Insert, search and delete over a memory kept in ascending order.
// ----------------------------------------------------------------------------
module sorted_list_engine #(
    parameter int DEPTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,  // [31:0] value
    input  wire  [1:0]  s_axis_tuser,  // [1:0] opcode
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata   // [1:0] status, [2] found, [7:3] entry_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // storage
    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] r_rdata;
    logic [AW-1:0]      rd_addr;
    logic               we;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    sle_pkg::t_state    r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;      // address issued
    logic               r_rv, n_rv;        // r_rdata valid for r_pidx
    logic [CW-1:0]      r_pidx, n_pidx;    // address of r_rdata
    logic [1:0]         r_op, n_op;
    logic signed [31:0] r_key, n_key;
    logic               r_found, n_found;
    logic               r_posok, n_posok;  // insert position found
    logic [CW-1:0]      r_pos, n_pos;      // insert position
    logic [CW-1:0]      r_hit, n_hit;      // first equal position
    logic signed [31:0] r_carry, n_carry;  // entry moved by insert shift
    logic [1:0]         r_st, n_st;
    logic [7:0]         r_res, n_res;
    logic               r_ovalid;          // output register holds a result
    logic [7:0]         r_out;
    logic               out_load;

    // hand the finished result to the output register when it is free or its result is taken
    assign out_load      = (r_state == sle_pkg::S_OUT) && (!r_ovalid || m_axis_tready);
    assign s_axis_tready = (r_state == sle_pkg::S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_rv    = 1'b0;
        n_pidx  = r_idx;
        n_op    = r_op;
        n_key   = r_key;
        n_found = r_found;
        n_posok = r_posok;
        n_pos   = r_pos;
        n_hit   = r_hit;
        n_carry = r_carry;
        n_st    = r_st;
        n_res   = r_res;
        rd_addr = r_idx[AW-1:0];
        we      = 1'b0;
        wr_addr = r_idx[AW-1:0];
        wr_data = r_key;
        case (r_state)
            sle_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op    = s_axis_tuser;
                    n_key   = s_axis_tdata;
                    n_found = 1'b0;
                    n_posok = 1'b0;
                    n_pos   = r_count;
                    n_hit   = r_count;
                    n_idx   = '0;
                    n_state = sle_pkg::S_SCAN;
                end
            end
            sle_pkg::S_SCAN: begin
                // issue next read, examine previous
                if (r_idx < r_count) begin
                    n_idx = r_idx + 1'b1;
                    n_rv  = 1'b1;
                end
                if (r_rv) begin
                    if (!r_posok && !(r_rdata < r_key)) begin
                        n_posok = 1'b1;
                        n_pos   = r_pidx;
                    end
                    if (!r_found && r_rdata == r_key) begin
                        n_found = 1'b1;
                        n_hit   = r_pidx;
                    end
                end
                if (!r_rv && r_idx >= r_count) begin
                    // scan over; decide
                    n_st = r_found ? sle_pkg::ST_DONE : sle_pkg::ST_MISSING;
                    n_state = sle_pkg::S_OUT;
                    if (r_op == sle_pkg::OP_INSERT) begin
                        n_st = sle_pkg::ST_DONE;
                        if (r_count >= CW'(DEPTH)) begin
                            n_st = sle_pkg::ST_FULL;
                        end else begin
                            n_idx   = r_pos;
                            n_carry = r_key;
                            n_count = r_count + 1'b1;
                            n_state = sle_pkg::S_SHIFT;
                            rd_addr = r_pos[AW-1:0];
                        end
                    end else if (r_op == sle_pkg::OP_DELETE && r_found) begin
                        n_idx   = r_hit;
                        n_count = r_count - 1'b1;
                        n_state = sle_pkg::S_SHIFT;
                        rd_addr = AW'(r_hit + 1'b1);
                    end
                    n_res = {5'(n_count), r_found, n_st};
                end
            end
            sle_pkg::S_SHIFT: begin
                // one entry moved per cycle; rdata holds old entry at r_idx (insert)
                // or at r_idx+1 (delete)
                if (r_op == sle_pkg::OP_INSERT) begin
                    we      = 1'b1;
                    wr_addr = r_idx[AW-1:0];
                    wr_data = r_carry;
                    n_carry = r_rdata;
                    n_idx   = r_idx + 1'b1;
                    rd_addr = AW'(r_idx + 1'b1);
                    if (r_idx + 1'b1 >= r_count) n_state = sle_pkg::S_OUT;
                end else begin
                    if (r_idx + 1'b1 >= CW'(r_count + 1'b1)) begin
                        n_state = sle_pkg::S_OUT;
                    end else begin
                        we      = 1'b1;
                        wr_addr = r_idx[AW-1:0];
                        wr_data = r_rdata;
                        n_idx   = r_idx + 1'b1;
                        rd_addr = AW'(r_idx + 2'd2);
                    end
                end
                n_res = {5'(r_count), r_found, r_st};
            end
            sle_pkg::S_OUT: begin
                if (out_load) n_state = sle_pkg::S_IDLE;
            end
            default: n_state = sle_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sle_pkg::S_IDLE;
            r_count <= '0;
            r_rv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rv    <= n_rv;
        end
        r_idx   <= n_idx;
        r_pidx  <= n_pidx;
        r_op    <= n_op;
        r_key   <= n_key;
        r_found <= n_found;
        r_posok <= n_posok;
        r_pos   <= n_pos;
        r_hit   <= n_hit;
        r_carry <= n_carry;
        r_st    <= n_st;
        r_res   <= n_res;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

endmodule : sorted_list_engine
`default_nettype wire

// ----- tb/sv/sle_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_checker: result checker for the sorted list engine
// Watches both stream channels, keeps its own ordered store to work out
// the result of each accepted request, and compares every returned result
// field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module sle_checker #(
    parameter int DEPTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_req_valid,
    input  wire         i_req_ready,
    input  wire  [31:0] i_req_value,
    input  wire  [1:0]  i_req_opcode,
    input  wire         i_res_valid,
    input  wire         i_res_ready,
    input  wire  [7:0]  i_res_data,
    output int          o_fail_count,
    output int          o_pending
);

    // shadow of the ordered store
    logic signed [31:0] keys [DEPTH];
    int                 key_count;
    logic [7:0]         result_queue [$];

    initial o_fail_count = 0;
    assign o_pending = result_queue.size();

    // apply one request to the shadow store, return {count, found, status}
    task automatic apply_request(input logic [1:0] op, input logic signed [31:0] key,
                                 output logic [7:0] res);
        int         hit;
        int         pos;
        logic       present;
        logic [1:0] status;
        hit = key_count;
        for (int i = key_count - 1; i >= 0; i--)
            if (keys[i] == key) hit = i;
        present = (hit < key_count);
        status  = sle_pkg::ST_DONE;
        if (op == sle_pkg::OP_INSERT) begin
            if (key_count >= DEPTH) begin
                status = sle_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < key_count && keys[pos] < key) pos++;
                for (int i = key_count; i > pos; i--) keys[i] = keys[i-1];
                keys[pos] = key;
                key_count++;
            end
        end else if (op == sle_pkg::OP_DELETE) begin
            if (!present) begin
                status = sle_pkg::ST_MISSING;
            end else begin
                for (int i = hit; i + 1 < key_count; i++) keys[i] = keys[i+1];
                key_count--;
            end
        end else if (!present) begin
            // search, and the unused opcode behaves the same
            status = sle_pkg::ST_MISSING;
        end
        res = {key_count[4:0], present, status};
    endtask

    always @(posedge i_clk) begin
        logic [7:0] res;
        logic [7:0] want;
        if (!i_rst_n) begin
            key_count = 0;
            result_queue.delete();
        end else begin
            // accepted request: predict
            if (i_req_valid && i_req_ready) begin
                apply_request(i_req_opcode, i_req_value, res);
                result_queue.push_back(res);
            end
            // accepted result: compare
            if (i_res_valid && i_res_ready) begin
                if (result_queue.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_res_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = result_queue.pop_front();
                    if (want[1:0] !== i_res_data[1:0] || want[2] !== i_res_data[2] ||
                        want[7:3] !== i_res_data[7:3]) begin
                        $display("%0t: status/found/count exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 $time, want[1:0], want[2], want[7:3],
                                 i_res_data[1:0], i_res_data[2], i_res_data[7:3]);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule : sle_checker

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the sorted list engine
// Drives directed and random insert/search/delete requests with idle and
// stall phases, a long result hold-off and a drain pause; the checker
// predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 500000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] value
    logic [1:0]  s_axis_tuser = '0;   // [1:0] opcode
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [7:0]  m_axis_tdata;        // [1:0] status, [2] found, [7:3] entry_count

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_cycles = 0;
    int cycle_count = 0;
    int fill_bias = 60;

    sorted_list_engine #(.DEPTH(DEPTH)) uut (.*);

    sle_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_value  (s_axis_tdata),
        .i_req_opcode (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready   <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // offer one request and wait until it is taken
    task automatic send_request(input logic [1:0] op, input logic [31:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // random request, keys mostly from a small pool so hits are common
    task automatic send_random;
        logic [1:0]  op;
        logic [31:0] val;
        int          r;
        r = $urandom_range(0, 99);
        if (r < fill_bias)                    op = sle_pkg::OP_INSERT;
        else if (r < fill_bias + (95 - fill_bias) / 2) op = sle_pkg::OP_SEARCH;
        else if (r < 95)                      op = sle_pkg::OP_DELETE;
        else                                  op = sle_pkg::OP_SPARE;
        r = $urandom_range(0, 9);
        if (r < 6)       val = $urandom_range(0, 7) - 3;
        else if (r == 6) val = 32'h8000_0000 + $urandom_range(0, 1);
        else if (r == 7) val = 32'h7FFF_FFFF - $urandom_range(0, 1);
        else             val = $urandom;
        send_request(op, val);
    endtask

    // let the checker log the last accepted request before looking at the count
    task automatic wait_drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, extremes, duplicates, unused opcode, full store
        send_request(sle_pkg::OP_SEARCH, 32'd5);
        send_request(sle_pkg::OP_DELETE, 32'd5);
        send_request(sle_pkg::OP_INSERT, 32'h7FFF_FFFF);
        send_request(sle_pkg::OP_INSERT, 32'h8000_0000);
        send_request(sle_pkg::OP_INSERT, 32'd0);
        send_request(sle_pkg::OP_INSERT, 32'd0);
        send_request(sle_pkg::OP_SEARCH, 32'd0);
        send_request(sle_pkg::OP_SPARE, 32'd0);
        send_request(sle_pkg::OP_SPARE, 32'd9);
        send_request(sle_pkg::OP_DELETE, 32'd0);
        for (int i = 0; i < 13; i++) send_request(sle_pkg::OP_INSERT, 32'd100 - 32'(i * 7));
        send_request(sle_pkg::OP_INSERT, 32'd1);            // full, value absent
        send_request(sle_pkg::OP_INSERT, 32'h7FFF_FFFF);    // full, value present
        send_request(sle_pkg::OP_DELETE, 32'h8000_0000);
        send_request(sle_pkg::OP_DELETE, 32'h1234_5678);
        wait_drain;

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 50 : (ph == 3) ? 24 : 0;
            recv_stall_pct = (ph == 2) ? 50 : (ph == 3) ? 24 : 0;
            if (ph == 1) hold_off_cycles <= 300;
            for (int n = 0; n < 232; n++) begin
                if (n % 58 == 0) fill_bias = (fill_bias == 60) ? 25 : 60;
                send_random();
            end
            // pause until every result has come back
            wait_drain;
        end

        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule : tb_top
